FILE: sv/prle_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the packbits run-length encoder
package prle_pkg;

   localparam int BYTE_W       = 8;
   localparam int FUNC_W       = 2;
   localparam int OUT_W        = 64;
   localparam int BYTE_COUNT_W = 4;
   localparam int MAX_CHUNK    = 128;
   localparam int RUN_BASE     = 257;
   localparam int CMDQ_DEPTH   = 4;
   localparam int CMDQ_PTR_W   = 2;
   localparam int CMDQ_CNT_W   = 3;

   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

   localparam logic [FUNC_W-1:0] FUNC_ENCODE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH_PAD = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NEW_FRAME = 2'd3;

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_LIT,
      CMD_RUN,
      CMD_PAD,
      CMD_CLEAR,
      CMD_END
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              has_byte;
      logic              last;
   } beat_type;

endpackage

FILE: sv/prle_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces
interface prle_req_if;
   logic                            valid;
   logic                            ready;
   logic [prle_pkg::FUNC_W-1:0]     func;
   logic [prle_pkg::BYTE_W-1:0]     data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface prle_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [prle_pkg::OUT_W-1:0]        out_bytes;
   logic [prle_pkg::BYTE_COUNT_W-1:0] byte_count;
   logic                              last;

   modport source (output valid, output out_bytes, output byte_count, output last,
                   input ready);
   modport sink   (input valid, input out_bytes, input byte_count, input last,
                   output ready);
endinterface

FILE: sv/packbits_run_length_encoder_unit.sv
`timescale 1ns / 1ps
// top level of the packbits run-length encoder
// PackBits encoder taking one request per byte (or a flush, flush-and-pad or new-frame
// request) and returning the encoded stream packed WORD_BYTES bytes per response word,
// first byte in lane 0, with last set on the final word caused by each request; a
// request that writes no byte gives no response. The front sequencer holds the request
// channel while it works: it takes a request, then steps through its push, literal,
// run, pad and end phases, issuing each push, literal or run command it needs and
// waiting while the command queue cannot take one; a new frame steps through clear
// and end instead. Commands pass through a four-entry queue to the back end, which
// writes literals into a LITERAL_DEPTH-entry memory with one write and one registered
// read port; it takes each command and then sends out one encoded byte per cycle
// while the packer accepts them, a literal chunk as a control byte and its data bytes
// and a run as a control byte and its value, while pad and end go out in the cycle
// their command is taken; the response register lets the next word build while one
// waits to be taken. New frame discards pending bytes; flush first to keep them.
module packbits_run_length_encoder_unit #(
   parameter int LITERAL_DEPTH = 132,
   parameter int WORD_BYTES    = 8
) (
   input logic        clock,
   input logic        reset,
   prle_req_if.sink   req_bus,
   prle_rsp_if.source rsp_bus
);

   logic               q_in_valid;
   logic               q_in_ready;
   prle_pkg::cmd_type  q_in_cmd;
   logic               q_out_valid;
   logic               q_out_ready;
   prle_pkg::cmd_type  q_out_cmd;
   logic               beat_valid;
   logic               beat_ready;
   prle_pkg::beat_type beat;

   prle_front #(
      .LITERAL_DEPTH (LITERAL_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_func      (req_bus.func),
      .req_data_byte (req_bus.data_byte),
      .cmd_valid     (q_in_valid),
      .cmd_ready     (q_in_ready),
      .cmd           (q_in_cmd)
   );

   prle_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_cmd    (q_in_cmd),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_cmd   (q_out_cmd)
   );

   prle_back #(
      .LITERAL_DEPTH (LITERAL_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_out_valid),
      .cmd_ready  (q_out_ready),
      .cmd        (q_out_cmd),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat)
   );

   prle_pack #(
      .WORD_BYTES (WORD_BYTES)
   ) u_pack (
      .clock          (clock),
      .reset          (reset),
      .beat_valid     (beat_valid),
      .beat_ready     (beat_ready),
      .beat           (beat),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_out_bytes  (rsp_bus.out_bytes),
      .rsp_byte_count (rsp_bus.byte_count),
      .rsp_last       (rsp_bus.last)
   );

endmodule

FILE: sv/prle_front.sv
`timescale 1ns / 1ps
// front sequencer: takes requests, tracks run and literal state, issues commands
module prle_front #(
   parameter int LITERAL_DEPTH = 132
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [prle_pkg::FUNC_W-1:0]   req_func,
   input  logic [prle_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output prle_pkg::cmd_type             cmd
);

   localparam int FILL_W = $clog2(LITERAL_DEPTH + 1);

   typedef enum logic [6:0] {
      F_IDLE  = 7'b0000001,
      F_PUSH  = 7'b0000010,
      F_LITS  = 7'b0000100,
      F_RUNS  = 7'b0001000,
      F_PAD   = 7'b0010000,
      F_CLEAR = 7'b0100000,
      F_END   = 7'b1000000
   } front_state_type;

   front_state_type                state_ff, state_in;
   logic [prle_pkg::BYTE_W-1:0]    prev_byte_ff, prev_byte_in;
   logic                           prev_valid_ff, prev_valid_in;
   logic [prle_pkg::BYTE_W-1:0]    rep_ff, rep_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic                           parity_ff, parity_in;
   logic [prle_pkg::FUNC_W-1:0]    func_ff, func_in;
   logic [prle_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic                           same_ff, same_in;
   logic [1:0]                     push_left_ff, push_left_in;
   logic                           lit_en_ff, lit_en_in;
   logic                           lit_all_ff, lit_all_in;
   logic                           run_all_ff, run_all_in;

   logic                           same;
   logic [prle_pkg::BYTE_W-1:0]    rep_inc;
   logic [prle_pkg::BYTE_W-1:0]    lit_n;
   logic [prle_pkg::BYTE_W-1:0]    run_n;
   logic                           lit_want;
   logic                           run_want;
   logic                           store_full;

   assign same       = prev_valid_ff && (req_data_byte == prev_byte_ff);
   assign rep_inc    = rep_ff + 8'd1;
   assign lit_n      = (fill_ff >= FILL_W'(prle_pkg::MAX_CHUNK)) ?
                       8'(prle_pkg::MAX_CHUNK) : 8'(fill_ff);
   assign run_n      = (rep_ff >= 8'(prle_pkg::MAX_CHUNK)) ? 8'(prle_pkg::MAX_CHUNK) : rep_ff;
   assign lit_want   = lit_en_ff && (lit_all_ff ? (fill_ff != '0) :
                       (fill_ff > FILL_W'(prle_pkg::MAX_CHUNK)));
   assign run_want   = run_all_ff ? (rep_ff != '0) : (rep_ff > 8'(prle_pkg::MAX_CHUNK));
   assign store_full = (fill_ff >= FILL_W'(LITERAL_DEPTH));
   assign req_ready  = (state_ff == F_IDLE);

   always_comb begin
      state_in      = state_ff;
      prev_byte_in  = prev_byte_ff;
      prev_valid_in = prev_valid_ff;
      rep_in        = rep_ff;
      fill_in       = fill_ff;
      parity_in     = parity_ff;
      func_in       = func_ff;
      byte_in       = byte_ff;
      same_in       = same_ff;
      push_left_in  = push_left_ff;
      lit_en_in     = lit_en_ff;
      lit_all_in    = lit_all_ff;
      run_all_in    = run_all_ff;
      cmd_valid     = 1'b0;
      cmd.op        = prle_pkg::CMD_END;
      cmd.value     = prev_byte_ff;
      cmd.count     = '0;

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               byte_in  = req_data_byte;
               same_in  = same;
               state_in = F_PUSH;
               case (req_func)
                  prle_pkg::FUNC_ENCODE: begin
                     if (same) begin
                        rep_in       = rep_inc;
                        push_left_in = 2'd0;
                        lit_en_in    = (rep_inc > 8'd2);
                        lit_all_in   = 1'b1;
                        run_all_in   = 1'b0;
                     end else begin
                        if (rep_ff == 8'd1 || rep_ff == 8'd2) begin
                           push_left_in = rep_ff[1:0];
                           rep_in       = '0;
                        end else begin
                           push_left_in = 2'd0;
                        end
                        lit_en_in  = 1'b1;
                        lit_all_in = 1'b0;
                        run_all_in = 1'b1;
                     end
                  end
                  prle_pkg::FUNC_FLUSH, prle_pkg::FUNC_FLUSH_PAD: begin
                     if (rep_ff == 8'd1) begin
                        push_left_in = 2'd1;
                        rep_in       = '0;
                     end else begin
                        push_left_in = 2'd0;
                     end
                     lit_en_in  = 1'b1;
                     lit_all_in = 1'b1;
                     run_all_in = 1'b1;
                  end
                  prle_pkg::FUNC_NEW_FRAME: begin
                     prev_byte_in  = '0;
                     prev_valid_in = 1'b0;
                     rep_in        = '0;
                     fill_in       = '0;
                     parity_in     = 1'b0;
                     state_in      = F_CLEAR;
                  end
                  default: begin
                     state_in = F_IDLE;
                  end
               endcase
            end
         end
         F_PUSH: begin
            if (push_left_ff == 2'd0) begin
               state_in = F_LITS;
            end else begin
               cmd_valid = !store_full;
               cmd.op    = prle_pkg::CMD_PUSH;
               if (cmd_ready || store_full) begin
                  push_left_in = push_left_ff - 2'd1;
                  if (!store_full) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
         end
         F_LITS: begin
            if (!lit_want) begin
               state_in = F_RUNS;
            end else begin
               cmd_valid = 1'b1;
               cmd.op    = prle_pkg::CMD_LIT;
               cmd.count = lit_n;
               if (cmd_ready) begin
                  fill_in   = fill_ff - FILL_W'(lit_n);
                  parity_in = parity_ff ^ ~lit_n[0];
               end
            end
         end
         F_RUNS: begin
            if (!run_want) begin
               state_in = F_PAD;
            end else begin
               cmd_valid = 1'b1;
               cmd.op    = prle_pkg::CMD_RUN;
               cmd.count = run_n;
               if (cmd_ready) begin
                  rep_in = rep_ff - run_n;
               end
            end
         end
         F_PAD: begin
            if (func_ff == prle_pkg::FUNC_FLUSH_PAD && parity_ff) begin
               cmd_valid = 1'b1;
               cmd.op    = prle_pkg::CMD_PAD;
               cmd.value = prle_pkg::PAD_BYTE;
               if (cmd_ready) begin
                  parity_in = 1'b0;
                  state_in  = F_END;
               end
            end else begin
               state_in = F_END;
            end
         end
         F_CLEAR: begin
            cmd_valid = 1'b1;
            cmd.op    = prle_pkg::CMD_CLEAR;
            if (cmd_ready) begin
               state_in = F_END;
            end
         end
         F_END: begin
            cmd_valid = 1'b1;
            cmd.op    = prle_pkg::CMD_END;
            if (cmd_ready) begin
               state_in = F_IDLE;
               if (func_ff == prle_pkg::FUNC_ENCODE) begin
                  if (!same_ff) begin
                     prev_byte_in  = byte_ff;
                     prev_valid_in = 1'b1;
                     rep_in        = 8'd1;
                  end
               end else begin
                  prev_byte_in  = '0;
                  prev_valid_in = 1'b0;
                  rep_in        = '0;
                  fill_in       = '0;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         prev_byte_ff  <= '0;
         prev_valid_ff <= 1'b0;
         rep_ff        <= '0;
         fill_ff       <= '0;
         parity_ff     <= 1'b0;
         push_left_ff  <= 2'd0;
         lit_en_ff     <= 1'b0;
         lit_all_ff    <= 1'b0;
         run_all_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_byte_ff  <= prev_byte_in;
         prev_valid_ff <= prev_valid_in;
         rep_ff        <= rep_in;
         fill_ff       <= fill_in;
         parity_ff     <= parity_in;
         push_left_ff  <= push_left_in;
         lit_en_ff     <= lit_en_in;
         lit_all_ff    <= lit_all_in;
         run_all_ff    <= run_all_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      byte_ff <= byte_in;
      same_ff <= same_in;
   end

endmodule

FILE: sv/prle_cmdq.sv
`timescale 1ns / 1ps
// short command queue between front sequencer and back end
module prle_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  prle_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output prle_pkg::cmd_type out_cmd
);

   prle_pkg::cmd_type                   slots_ff [prle_pkg::CMDQ_DEPTH];
   logic [prle_pkg::CMDQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [prle_pkg::CMDQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [prle_pkg::CMDQ_CNT_W-1:0]     count_ff, count_in;
   logic                                do_write;
   logic                                do_read;

   assign in_ready  = (count_ff != prle_pkg::CMDQ_CNT_W'(prle_pkg::CMDQ_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slots_ff[rd_ptr_ff];
   assign do_write  = in_valid && in_ready;
   assign do_read   = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = do_write ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_read ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slots_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

FILE: sv/prle_back.sv
`timescale 1ns / 1ps
// back end: literal memory and byte sequencer for chunks, runs and pads
module prle_back #(
   parameter int LITERAL_DEPTH = 132
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  prle_pkg::cmd_type  cmd,
   output logic               beat_valid,
   input  logic               beat_ready,
   output prle_pkg::beat_type beat
);

   localparam int PTR_W = $clog2(LITERAL_DEPTH);

   typedef enum logic [4:0] {
      B_FETCH    = 5'b00001,
      B_LIT_CTRL = 5'b00010,
      B_LIT_DATA = 5'b00100,
      B_RUN_CTRL = 5'b01000,
      B_RUN_BYTE = 5'b10000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   logic [PTR_W-1:0]               head_ff, head_in;
   logic [PTR_W-1:0]               tail_ff, tail_in;
   logic [prle_pkg::BYTE_W-1:0]    left_ff, left_in;
   logic [prle_pkg::BYTE_W-1:0]    value_ff, value_in;
   logic [prle_pkg::BYTE_W-1:0]    rdata_ff;
   logic [prle_pkg::BYTE_W-1:0]    store_mem [LITERAL_DEPTH];
   logic                           wr_en;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(LITERAL_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      left_in       = left_ff;
      value_in      = value_ff;
      wr_en         = 1'b0;
      cmd_ready     = 1'b0;
      beat_valid    = 1'b0;
      beat.value    = '0;
      beat.has_byte = 1'b1;
      beat.last     = 1'b0;

      case (state_ff)
         B_FETCH: begin
            if (cmd_valid) begin
               case (cmd.op)
                  prle_pkg::CMD_PUSH: begin
                     cmd_ready = 1'b1;
                     wr_en     = 1'b1;
                     tail_in   = ptr_inc(tail_ff);
                  end
                  prle_pkg::CMD_CLEAR: begin
                     cmd_ready = 1'b1;
                     head_in   = tail_ff;
                  end
                  prle_pkg::CMD_LIT: begin
                     cmd_ready = 1'b1;
                     left_in   = cmd.count;
                     state_in  = B_LIT_CTRL;
                  end
                  prle_pkg::CMD_RUN: begin
                     cmd_ready = 1'b1;
                     left_in   = cmd.count;
                     value_in  = cmd.value;
                     state_in  = B_RUN_CTRL;
                  end
                  prle_pkg::CMD_PAD: begin
                     beat_valid = 1'b1;
                     beat.value = prle_pkg::PAD_BYTE;
                     cmd_ready  = beat_ready;
                  end
                  prle_pkg::CMD_END: begin
                     beat_valid    = 1'b1;
                     beat.has_byte = 1'b0;
                     beat.last     = 1'b1;
                     cmd_ready     = beat_ready;
                  end
                  default: begin
                     cmd_ready = 1'b1;
                  end
               endcase
            end
         end
         B_LIT_CTRL: begin
            beat_valid = 1'b1;
            beat.value = left_ff - 8'd1;
            if (beat_ready) begin
               state_in = B_LIT_DATA;
            end
         end
         B_LIT_DATA: begin
            beat_valid = 1'b1;
            beat.value = rdata_ff;
            if (beat_ready) begin
               head_in = ptr_inc(head_ff);
               left_in = left_ff - 8'd1;
               if (left_ff == 8'd1) begin
                  state_in = B_FETCH;
               end
            end
         end
         B_RUN_CTRL: begin
            beat_valid = 1'b1;
            beat.value = 8'(9'(prle_pkg::RUN_BASE) - {1'b0, left_ff});
            if (beat_ready) begin
               state_in = B_RUN_BYTE;
            end
         end
         B_RUN_BYTE: begin
            beat_valid = 1'b1;
            beat.value = value_ff;
            if (beat_ready) begin
               state_in = B_FETCH;
            end
         end
         default: begin
            state_in = B_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_FETCH;
         head_ff  <= '0;
         tail_ff  <= '0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // literal store, read pointer follows the next head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[tail_ff] <= cmd.value;
      end
      rdata_ff <= store_mem[head_in];
   end

endmodule

FILE: sv/prle_pack.sv
`timescale 1ns / 1ps
// byte packer: gathers bytes into response words and marks the last word
module prle_pack #(
   parameter int WORD_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                beat_valid,
   output logic                                beat_ready,
   input  prle_pkg::beat_type                  beat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [prle_pkg::OUT_W-1:0]          rsp_out_bytes,
   output logic [prle_pkg::BYTE_COUNT_W-1:0]   rsp_byte_count,
   output logic                                rsp_last
);

   localparam int CNT_W = $clog2(WORD_BYTES + 1);

   logic [prle_pkg::OUT_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         out_valid_ff, out_valid_in;
   logic [prle_pkg::OUT_W-1:0]   out_word_ff, out_word_in;
   logic [CNT_W-1:0]             out_count_ff, out_count_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_free;
   logic                         word_full;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign word_full = (count_ff == CNT_W'(WORD_BYTES));

   always_comb begin
      acc_in       = acc_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_word_in  = out_word_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      beat_ready   = 1'b0;

      if (beat_valid) begin
         if (beat.has_byte) begin
            if (!word_full) begin
               beat_ready = 1'b1;
               if (count_ff == '0) begin
                  acc_in = prle_pkg::OUT_W'(beat.value);
               end else begin
                  for (int j = 0; j < WORD_BYTES; j++) begin
                     if (count_ff == CNT_W'(j)) begin
                        acc_in[8*j +: 8] = beat.value;
                     end
                  end
               end
               count_in = count_ff + 1'b1;
            end else if (out_free) begin
               beat_ready   = 1'b1;
               out_valid_in = 1'b1;
               out_word_in  = acc_ff;
               out_count_in = count_ff;
               out_last_in  = 1'b0;
               acc_in       = prle_pkg::OUT_W'(beat.value);
               count_in     = CNT_W'(1);
            end
         end else begin
            if (count_ff == '0) begin
               beat_ready = 1'b1;
            end else if (out_free) begin
               beat_ready   = 1'b1;
               out_valid_in = 1'b1;
               out_word_in  = acc_ff;
               out_count_in = count_ff;
               out_last_in  = beat.last;
               count_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      out_word_ff  <= out_word_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_bytes  = out_word_ff;
   assign rsp_byte_count = prle_pkg::BYTE_COUNT_W'(out_count_ff);
   assign rsp_last       = out_last_ff;

endmodule

FILE: sim/packbits_run_length_encoder_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the packbits run-length encoder unit
module packbits_run_length_encoder_unit_tb;

   localparam int LITERAL_DEPTH  = 132;
   localparam int WORD_BYTES     = 8;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int PHASE_ITEMS    = 10;

   typedef struct {
      logic [prle_pkg::FUNC_W-1:0] func;
      logic [prle_pkg::BYTE_W-1:0] data_byte;
   } enc_req_type;

   typedef struct {
      logic [prle_pkg::OUT_W-1:0]        out_bytes;
      logic [prle_pkg::BYTE_COUNT_W-1:0] byte_count;
      logic                              last;
   } enc_word_type;

   logic clock;
   logic reset;

   prle_req_if req_ch ();
   prle_rsp_if rsp_ch ();

   packbits_run_length_encoder_unit #(
      .LITERAL_DEPTH (LITERAL_DEPTH),
      .WORD_BYTES    (WORD_BYTES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   enc_req_type  pending_reqs[$];
   enc_word_type expected_words[$];
   int           n_queued;
   int           n_taken;
   int           err_count;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           hold_asked;
   int           hold_done;
   int           hold_left;
   int           stall_cycles;

   // encoder state mirror
   logic [prle_pkg::BYTE_W-1:0] prev_byte;
   logic                        prev_ok;
   logic [7:0]                  rep_cnt;
   logic [prle_pkg::BYTE_W-1:0] lit_q[$];
   logic                        out_parity;
   logic [prle_pkg::BYTE_W-1:0] enc_bytes[$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      err_count++;
   endtask

   function automatic void emit_byte(input logic [prle_pkg::BYTE_W-1:0] v);
      enc_bytes.push_back(v);
      out_parity ^= 1'b1;
   endfunction

   function automatic void lit_push(input logic [prle_pkg::BYTE_W-1:0] v);
      if (lit_q.size() < LITERAL_DEPTH)
         lit_q.push_back(v);
   endfunction

   function automatic void lit_chunk();
      int n;
      n = (lit_q.size() < prle_pkg::MAX_CHUNK) ? lit_q.size() : prle_pkg::MAX_CHUNK;
      if (n > 0) begin
         emit_byte(prle_pkg::BYTE_W'(n - 1));
         repeat (n) emit_byte(lit_q.pop_front());
      end
   endfunction

   function automatic void lit_flush_all();
      while (lit_q.size() > 0) lit_chunk();
   endfunction

   function automatic void run_flush();
      int n;
      while (rep_cnt > 0) begin
         n = (rep_cnt < prle_pkg::MAX_CHUNK) ? rep_cnt : prle_pkg::MAX_CHUNK;
         emit_byte(prle_pkg::BYTE_W'(prle_pkg::RUN_BASE - n));
         emit_byte(prev_byte);
         rep_cnt -= 8'(n);
      end
   endfunction

   function automatic void clear_state();
      prev_byte  = '0;
      prev_ok    = 1'b0;
      rep_cnt    = '0;
      out_parity = 1'b0;
      lit_q.delete();
   endfunction

   function automatic void encode_byte(input logic [prle_pkg::BYTE_W-1:0] b);
      if (prev_ok && b == prev_byte) begin
         rep_cnt++;
         if (rep_cnt > 2 && lit_q.size() > 0) begin
            lit_flush_all();
         end else if (rep_cnt > prle_pkg::MAX_CHUNK) begin
            emit_byte(prle_pkg::BYTE_W'(prle_pkg::RUN_BASE - prle_pkg::MAX_CHUNK));
            emit_byte(prev_byte);
            rep_cnt -= 8'(prle_pkg::MAX_CHUNK);
         end
      end else begin
         if (rep_cnt == 1) begin
            lit_push(prev_byte);
         end else if (rep_cnt == 2) begin
            lit_push(prev_byte);
            lit_push(prev_byte);
         end else if (rep_cnt > 2) begin
            run_flush();
         end
         while (lit_q.size() > prle_pkg::MAX_CHUNK) lit_chunk();
         prev_byte = b;
         prev_ok   = 1'b1;
         rep_cnt   = 8'd1;
      end
   endfunction

   function automatic void flush_segment();
      if (rep_cnt < 2) begin
         while (rep_cnt > 0) begin
            lit_push(prev_byte);
            rep_cnt--;
         end
      end
      lit_flush_all();
      if (rep_cnt >= 2)
         run_flush();
      prev_byte = '0;
      prev_ok   = 1'b0;
      rep_cnt   = '0;
      lit_q.delete();
   endfunction

   // works out the response words for one accepted request
   function automatic void predict_request(input logic [prle_pkg::FUNC_W-1:0] func,
                                           input logic [prle_pkg::BYTE_W-1:0] data_byte);
      int           nwords;
      int           nb;
      enc_word_type w;
      enc_bytes.delete();
      case (func)
         prle_pkg::FUNC_ENCODE: begin
            encode_byte(data_byte);
         end
         prle_pkg::FUNC_FLUSH: begin
            flush_segment();
         end
         prle_pkg::FUNC_FLUSH_PAD: begin
            flush_segment();
            if (out_parity)
               emit_byte(prle_pkg::PAD_BYTE);
         end
         default: begin
            clear_state();
         end
      endcase
      nwords = (enc_bytes.size() + WORD_BYTES - 1) / WORD_BYTES;
      for (int k = 0; k < nwords; k++) begin
         nb = enc_bytes.size() - k * WORD_BYTES;
         if (nb > WORD_BYTES)
            nb = WORD_BYTES;
         w.out_bytes = '0;
         for (int j = 0; j < nb; j++)
            w.out_bytes[8*j +: 8] = enc_bytes[k * WORD_BYTES + j];
         w.byte_count = prle_pkg::BYTE_COUNT_W'(nb);
         w.last       = (k + 1 == nwords);
         expected_words.push_back(w);
      end
   endfunction

   task automatic push_request(input logic [prle_pkg::FUNC_W-1:0] func,
                               input logic [prle_pkg::BYTE_W-1:0] data_byte);
      enc_req_type r;
      r.func      = func;
      r.data_byte = data_byte;
      pending_reqs.push_back(r);
      n_queued++;
   endtask

   task automatic push_byte_run(input logic [prle_pkg::BYTE_W-1:0] b, input int len);
      repeat (len) push_request(prle_pkg::FUNC_ENCODE, b);
   endtask

   // random pieces of literals, runs, pairs and control requests, closed by a flush
   task automatic add_random_segment(inout int added);
      int                          pieces;
      int                          kind;
      int                          len;
      logic [prle_pkg::BYTE_W-1:0] b;
      pieces = $urandom_range(1, 4);
      for (int p = 0; p < pieces; p++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               push_request(prle_pkg::FUNC_ENCODE, prle_pkg::BYTE_W'($urandom));
            added += len;
         end else if (kind < 8) begin
            b   = prle_pkg::BYTE_W'($urandom);
            len = $urandom_range(1, (kind == 7) ? 20 : 5);
            push_byte_run(b, len);
            added += len;
         end else if (kind == 8) begin
            b = prle_pkg::BYTE_W'($urandom);
            push_byte_run(b, 2);
            push_request(prle_pkg::FUNC_ENCODE, ~b);
            added += 3;
         end else begin
            push_request(prle_pkg::FUNC_W'($urandom_range(1, 3)),
                         prle_pkg::BYTE_W'($urandom));
            added++;
         end
      end
      push_request(($urandom_range(0, 3) == 0) ? prle_pkg::FUNC_FLUSH_PAD :
                   prle_pkg::FUNC_FLUSH, prle_pkg::BYTE_W'($urandom));
      added++;
   endtask

   task automatic wait_drained();
      while (n_taken != n_queued || expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      int added;
      added          = 0;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (added < PHASE_ITEMS) add_random_segment(added);
      wait_drained();
   endtask

   // request driver
   always @(posedge clock) begin
      enc_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_request(req_ch.func, req_ch.data_byte);
            n_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.func      <= nxt.func;
               req_ch.data_byte <= nxt.data_byte;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_left = LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // response checker and watchdog
   always @(posedge clock) begin
      enc_word_type exp_w;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected response %h count %0d last %0b",
                                         rsp_ch.out_bytes, rsp_ch.byte_count,
                                         rsp_ch.last));
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_ch.out_bytes !== exp_w.out_bytes)
                  report_mismatch($sformatf("out_bytes %h, expected %h",
                                            rsp_ch.out_bytes, exp_w.out_bytes));
               if (rsp_ch.byte_count !== exp_w.byte_count)
                  report_mismatch($sformatf("byte_count %0d, expected %0d",
                                            rsp_ch.byte_count, exp_w.byte_count));
               if (rsp_ch.last !== exp_w.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_ch.last, exp_w.last));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (n_taken == n_queued && expected_words.size() == 0)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            report_mismatch($sformatf("watchdog expired with %0d responses outstanding",
                                      expected_words.size()));
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.func      = prle_pkg::FUNC_ENCODE;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      n_queued         = 0;
      n_taken          = 0;
      err_count        = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_asked       = 0;
      hold_done        = 0;
      clear_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed requests
      push_request(prle_pkg::FUNC_FLUSH, 8'hA5);
      push_request(prle_pkg::FUNC_FLUSH_PAD, 8'h5A);
      push_request(prle_pkg::FUNC_NEW_FRAME, 8'hFF);
      push_request(prle_pkg::FUNC_ENCODE, 8'h00);
      push_request(prle_pkg::FUNC_ENCODE, 8'hFF);
      push_request(prle_pkg::FUNC_FLUSH, 8'h3C);
      push_request(prle_pkg::FUNC_FLUSH_PAD, 8'hC3);
      push_request(prle_pkg::FUNC_FLUSH_PAD, 8'hFF);
      push_byte_run(8'h41, 3);
      push_request(prle_pkg::FUNC_ENCODE, 8'h42);
      push_request(prle_pkg::FUNC_FLUSH, 8'h00);
      push_byte_run(8'h55, 2);
      push_request(prle_pkg::FUNC_ENCODE, 8'h66);
      push_request(prle_pkg::FUNC_FLUSH_PAD, 8'h81);
      push_request(prle_pkg::FUNC_ENCODE, 8'h80);
      push_request(prle_pkg::FUNC_ENCODE, 8'h7F);
      push_request(prle_pkg::FUNC_NEW_FRAME, 8'h80);
      push_byte_run(8'hAA, 2);
      push_request(prle_pkg::FUNC_FLUSH, 8'hAA);
      push_request(prle_pkg::FUNC_ENCODE, 8'h01);
      push_request(prle_pkg::FUNC_FLUSH_PAD, 8'hFE);
      wait_drained();

      run_random_phase(0, 0);
      run_random_phase(67, 0);
      run_random_phase(0, 67);
      run_random_phase(18, 18);

      // long response hold-off while short segments keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asked++;
      for (int i = 0; i < 8; i++) begin
         push_request(prle_pkg::FUNC_ENCODE, prle_pkg::BYTE_W'($urandom));
         push_request(prle_pkg::FUNC_FLUSH, prle_pkg::BYTE_W'($urandom));
      end
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/prle_pkg.sv
sv/prle_if.sv
sv/prle_front.sv
sv/prle_cmdq.sv
sv/prle_back.sv
sv/prle_pack.sv
sv/packbits_run_length_encoder_unit.sv
sim/packbits_run_length_encoder_unit_tb.sv
